[design/blake2b_keyed_hash_unit_assert.svh]
// Assertion macros shared by the keyed hash unit modules.
// Depends on nothing; include after the module ports are declared.
`ifndef BLAKE2B_KEYED_HASH_UNIT_ASSERT_SVH
`define BLAKE2B_KEYED_HASH_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define B2_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define B2_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/b2b_pkg.sv]
// Shared types and constants for the keyed hash unit.
// No dependencies.
package b2b_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] PARAM_CONST = 64'h0000000001010000;
  localparam int unsigned ROUNDS = 12;
  localparam logic [7:0] BLOCK_BYTES = 8'd128;

  localparam logic [6:0] REG_DIGEST_BYTES = 7'd0;
  localparam logic [6:0] REG_KEY_BYTES    = 7'd1;

  typedef logic [3:0] sel_t;

  // message schedule, one row per round
  function automatic sel_t sigma(input logic [3:0] r, input logic [3:0] i);
    logic [63:0] row;
    unique case (r)
      4'd0, 4'd10: row = 64'hfedcba9876543210;
      4'd1, 4'd11: row = 64'h357b20c16df984ae;
      4'd2:  row = 64'h491763eadf250c8b; // packed little nibble first
      4'd3:  row = 64'h8f04a562ebcd1397;
      4'd4:  row = 64'hd386cb1efa427509;
      4'd5:  row = 64'h91ef57d438b0a6c2;
      4'd6:  row = 64'hb8293670a4def15c;
      4'd7:  row = 64'ha2684f05931ce7bd;
      4'd8:  row = 64'h5a417d2c803b9ef6;
      4'd9:  row = 64'h0dc3e9bf5167482a;
      default: row = 64'hfedcba9876543210;
    endcase
    return row[i*4 +: 4];
  endfunction

  typedef struct packed {
    logic load_chain;   // reload chain from IV and params
    logic write_word;   // store incoming word into buffer
    logic start_comp;   // begin compression
    logic comp_final;   // final flag for this compression
    logic pad_buffer;   // zero buffer words past fill
    logic clear_msg;    // return to message start
  } dp_cmd_t;

  typedef struct packed {
    logic       comp_done;
    logic       msg_start;
    logic       buf_full;
  } dp_sts_t;

endpackage

[design/blake2b_keyed_hash_unit.sv]
// BLAKE2b keyed hash unit. One 64-bit little-endian word is taken per input beat; a beat
// with data that arrives on a full block waits while that block is compressed (four mix
// lanes, one half-round per cycle), so no word is taken until that compression ends.
// After the last word is accepted the buffer is padded and a final compression runs; the
// first digest beat is offered once it has ended, then digest beats leave one per cycle
// of out_ready. The user must make configuration writes between messages for them to
// take effect at the next message; the block itself does not enforce this.
module blake2b_keyed_hash_unit
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_message_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [3:0]  out_digest_word_bytes,
  output logic        out_digest_last
);

  logic [6:0] dig_r, key_r, dig_c, key_c;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [3:0] nb_eff;
  logic [63:0] chain [8];
  logic [2:0] idx;
  logic [63:0] w;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r <= 7'd64;
      key_r <= 7'd0;
    end else if (cfg_valid) begin
      if ({6'd0, cfg_index} == REG_DIGEST_BYTES) dig_r <= cfg_data;
      else key_r <= cfg_data;
    end
  end
  assign dig_c = (dig_r == 7'd0) ? 7'd1 : ((dig_r > 7'd64) ? 7'd64 : dig_r);
  assign key_c = (key_r > 7'd64) ? 7'd64 : key_r;

  b2b_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_nb_raw(in_word_bytes),
    .in_last(in_last_word), .nb_eff, .cmd, .sts, .dig_len(dig_c),
    .out_valid, .out_ready, .out_idx(idx), .out_nb(out_digest_word_bytes),
    .out_last(out_digest_last)
  );

  b2b_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_word(in_message_word), .in_nb(nb_eff),
    .dig_len(dig_c), .key_len(key_c), .chain_out(chain)
  );

  always_comb begin
    w = chain[idx];
    for (int b = 0; b < 8; b++)
      if (4'(b) >= out_digest_word_bytes) w[b*8 +: 8] = 8'h00;
  end
  assign out_digest_word = w;

endmodule

[design/b2b_datapath.sv]
// Datapath: block buffer, counters, chain value and a four-lane half-round engine.
// Depends on b2b_pkg and the assertion macro header.
module b2b_datapath
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [63:0] in_word,
  input  logic [3:0]  in_nb,
  input  logic [6:0]  dig_len,
  input  logic [6:0] key_len,
  output logic [63:0] chain_out [8]
);

  logic [63:0] buf_r [16];
  logic [7:0]  fill_r;
  logic [63:0] cnt_lo_r, cnt_hi_r;
  logic [63:0] h_r [8];
  logic [63:0] v_r [16];
  logic [4:0]  step_r;
  logic        busy_r;
  logic        done_r;

  logic [63:0] masked;
  logic [3:0]  rnd;
  logic        diag;
  logic [63:0] vn [16];
  logic [63:0] t_lo, t_hi, addv;
  logic        carry;

  always_comb begin
    masked = in_word;
    for (int b = 0; b < 8; b++)
      if (4'(b) >= in_nb) masked[b*8 +: 8] = 8'h00;
  end

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  assign rnd  = step_r[4:1];
  assign diag = step_r[0];

  always_comb begin
    logic [63:0] a, b, c, d, x, y;
    int ia, ib, ic, id;
    vn = v_r;
    for (int g = 0; g < 4; g++) begin
      ia = g;
      ib = diag ? 4 + ((g + 1) % 4) : 4 + g;
      ic = diag ? 8 + ((g + 2) % 4) : 8 + g;
      id = diag ? 12 + ((g + 3) % 4) : 12 + g;
      x = buf_r[sigma(rnd, 4'(diag ? 8 + 2*g : 2*g))];
      y = buf_r[sigma(rnd, 4'(diag ? 9 + 2*g : 2*g + 1))];
      a = v_r[ia]; b = v_r[ib]; c = v_r[ic]; d = v_r[id];
      a = a + b + x;
      d = ror(d ^ a, 32);
      c = c + d;
      b = ror(b ^ c, 24);
      a = a + b + y;
      d = ror(d ^ a, 16);
      c = c + d;
      b = ror(b ^ c, 63);
      vn[ia] = a; vn[ib] = b; vn[ic] = c; vn[id] = d;
    end
  end

  always_comb begin
    addv = cmd.comp_final ? {56'd0, fill_r} : {56'd0, BLOCK_BYTES};
    {carry, t_lo} = {1'b0, cnt_lo_r} + {1'b0, addv};
    t_hi = cnt_hi_r + {63'd0, carry};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load_chain) begin
        for (int i = 0; i < 8; i++)
          h_r[i] <= (i == 0) ?
                    IV[0] ^ PARAM_CONST ^ {49'd0, key_len, 8'd0} ^ {57'd0, dig_len} :
                    IV[i];
      end
      if (cmd.start_comp) begin
        cnt_lo_r <= t_lo;
        cnt_hi_r <= t_hi;
        for (int i = 0; i < 8; i++) begin
          v_r[i]   <= h_r[i];
          v_r[i+8] <= IV[i];
        end
        v_r[12] <= IV[4] ^ t_lo;
        v_r[13] <= IV[5] ^ t_hi;
        v_r[14] <= cmd.comp_final ? ~IV[6] : IV[6];
        busy_r <= 1'b1;
        step_r <= '0;
        if (!cmd.comp_final) fill_r <= '0;
      end else if (busy_r) begin
        v_r <= vn;
        if (step_r == 5'(2*ROUNDS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] ^ vn[i] ^ vn[i+8];
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
      if (cmd.write_word) begin
        buf_r[fill_r[6:3]] <= masked;
        fill_r <= fill_r + {4'd0, in_nb};
      end
      if (cmd.pad_buffer)
        for (int i = 0; i < 16; i++)
          if (5'(i) >= 5'((fill_r + 8'd7) >> 3)) buf_r[i] <= '0;
      if (cmd.clear_msg) begin
        fill_r <= '0; cnt_lo_r <= '0; cnt_hi_r <= '0;
      end
    end
  end

  assign sts.comp_done = done_r;
  assign sts.msg_start = (fill_r == 8'd0) && (cnt_lo_r == '0) && (cnt_hi_r == '0);
  assign sts.buf_full  = (fill_r >= BLOCK_BYTES);
  assign chain_out = h_r;

  `include "blake2b_keyed_hash_unit_assert.svh"
  `B2_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_r <= BLOCK_BYTES)
  `B2_ASSERT_NXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `B2_ASSERT_IMP(a_no_restart, clk, rst_n, busy_r, !cmd.start_comp)

endmodule

[design/b2b_ctrl.sv]
// Controller: sequences word intake, compressions and digest output.
// Depends on b2b_pkg and the assertion macro header.
module b2b_ctrl
  import b2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_nb_raw,
  input  logic        in_last,
  output logic [3:0]  nb_eff,
  output dp_cmd_t     cmd,
  input  dp_sts_t     sts,
  input  logic [6:0]  dig_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_idx,
  output logic [3:0]  out_nb,
  output logic        out_last
);

  typedef enum logic [2:0] {S_IDLE, S_MID, S_LASTW, S_FIN, S_EMIT} state_t;
  state_t state_r;
  logic [2:0] idx_r;
  logic [6:0] left;
  logic       acc;
  logic       need_comp;

  // a waiting beat with data holds until the full block is compressed
  assign need_comp = sts.buf_full && (nb_eff != 4'd0);
  assign in_ready = (state_r == S_IDLE) && !need_comp;
  assign acc = in_valid && in_ready;
  always_comb begin
    nb_eff = in_last ? ((in_nb_raw > 4'd8) ? 4'd8 : in_nb_raw) : 4'd8;
  end

  assign left = dig_len - {1'b0, idx_r, 3'd0};
  assign out_valid = (state_r == S_EMIT);
  assign out_idx = idx_r;
  assign out_nb = (left > 7'd8) ? 4'd8 : left[3:0];
  assign out_last = (left <= 7'd8);

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load_chain = sts.msg_start;
          cmd.write_word = (nb_eff != 4'd0);
        end else if (in_valid && need_comp) begin
          cmd.start_comp = 1'b1;
        end
      end
      S_MID: ;
      S_LASTW: begin
        cmd.pad_buffer = 1'b1;
        cmd.start_comp = 1'b1;
        cmd.comp_final = 1'b1;
      end
      S_FIN: ;
      S_EMIT: if (out_ready && out_last) begin
        cmd.clear_msg = 1'b1;
        cmd.load_chain = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && need_comp) state_r <= S_MID;
          else if (acc && in_last) state_r <= S_LASTW;
        end
        S_MID: if (sts.comp_done) state_r <= S_IDLE;
        S_LASTW: state_r <= S_FIN;
        S_FIN: if (sts.comp_done) begin
          state_r <= S_EMIT;
          idx_r <= '0;
        end
        S_EMIT: if (out_ready) begin
          if (out_last) state_r <= S_IDLE;
          else idx_r <= idx_r + 3'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "blake2b_keyed_hash_unit_assert.svh"
  `B2_ASSERT_IMP(a_emit_len, clk, rst_n, out_valid, out_nb != 4'd0)
  `B2_ASSERT_IMP(a_busy_noacc, clk, rst_n, state_r != S_IDLE, !in_ready)
  `B2_ASSERT_NXT(a_lastw_fin, clk, rst_n, state_r == S_LASTW, state_r == S_FIN)

endmodule

[dv/blake2b_keyed_hash_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for blake2b_keyed_hash_unit: directed and random messages, keyed and unkeyed,
// checked beat by beat against a BLAKE2b digest predictor. Depends on b2b_pkg and the RTL.
module blake2b_keyed_hash_unit_tb;
  import b2b_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  localparam logic [3:0] SCHED [10][16] = '{
    '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
    '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
    '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
    '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
    '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
    '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
    '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
    '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
    '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
    '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
  };

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    logic [6:0]   digest_len;
    logic [6:0]   key_len;
    logic [63:0]  chain [8];
    logic [63:0]  blk [16];
    int unsigned  fill;
    logic [63:0]  cnt_lo, cnt_hi;
    digest_beat_t pending [$];
    int unsigned  errors;

    function new();
      digest_len = 7'd64;
      key_len = 7'd0;
      errors = 0;
      clear();
    endfunction

    function int unsigned out_len();
      if (digest_len == 0) return 1;
      if (digest_len > 64) return 64;
      return digest_len;
    endfunction

    function void load();
      logic [63:0] kl;
      kl = (key_len > 64) ? 64'd64 : 64'(key_len);
      foreach (chain[i]) chain[i] = IV[i];
      chain[0] ^= PARAM_CONST ^ (kl << 8) ^ 64'(out_len());
    endfunction

    function void clear();
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      cnt_lo = '0;
      cnt_hi = '0;
      load();
    endfunction

    function void set_reg(logic idx, logic [6:0] val);
      if (idx == REG_DIGEST_BYTES[0]) digest_len = val;
      else key_len = val;
    endfunction

    function void add_count(logic [63:0] n);
      cnt_lo += n;
      if (cnt_lo < n) cnt_hi += 1;
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void g(ref logic [63:0] v [16], input int a, b, c, d,
                    input logic [63:0] x, y);
      v[a] = v[a] + v[b] + x;
      v[d] = ror(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];
      v[b] = ror(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y;
      v[d] = ror(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = ror(v[b] ^ v[c], 63);
    endfunction

    function void compress(bit fin);
      logic [63:0] v [16];
      int s;
      for (int i = 0; i < 8; i++) begin
        v[i] = chain[i];
        v[i+8] = IV[i];
      end
      v[12] ^= cnt_lo;
      v[13] ^= cnt_hi;
      if (fin) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
        s = r % 10;
        g(v, 0, 4,  8, 12, blk[SCHED[s][0]],  blk[SCHED[s][1]]);
        g(v, 1, 5,  9, 13, blk[SCHED[s][2]],  blk[SCHED[s][3]]);
        g(v, 2, 6, 10, 14, blk[SCHED[s][4]],  blk[SCHED[s][5]]);
        g(v, 3, 7, 11, 15, blk[SCHED[s][6]],  blk[SCHED[s][7]]);
        g(v, 0, 5, 10, 15, blk[SCHED[s][8]],  blk[SCHED[s][9]]);
        g(v, 1, 6, 11, 12, blk[SCHED[s][10]], blk[SCHED[s][11]]);
        g(v, 2, 7,  8, 13, blk[SCHED[s][12]], blk[SCHED[s][13]]);
        g(v, 3, 4,  9, 14, blk[SCHED[s][14]], blk[SCHED[s][15]]);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
    endfunction

    function void note_word(logic [63:0] w, logic [3:0] nb_in, logic last);
      int unsigned nb, total, nwords, left;
      digest_beat_t e;
      nb = (nb_in > 8) ? 8 : nb_in;
      if (!last) nb = 8;
      if (fill == 0 && cnt_lo == 0 && cnt_hi == 0) load();
      if (nb > 0) begin
        if (fill >= 128) begin
          add_count(64'd128);
          compress(0);
          fill = 0;
        end
        if (nb < 8) w &= (64'd1 << (8 * nb)) - 64'd1;
        blk[(fill >> 3) & 15] = w;
        fill += nb;
      end
      if (!last) return;
      add_count(64'(fill));
      for (int i = (fill + 7) >> 3; i < 16; i++) blk[i] = '0;
      compress(1);
      total = out_len();
      nwords = (total + 7) >> 3;
      for (int i = 0; i < nwords; i++) begin
        left = total - 8 * i;
        e.nbytes = (left > 8) ? 4'd8 : 4'(left);
        e.word = chain[i];
        if (e.nbytes < 8) e.word &= (64'd1 << (8 * e.nbytes)) - 64'd1;
        e.last = (i + 1 == nwords);
        pending.push_back(e);
      end
      clear();
    endfunction

    function void check_beat(logic [63:0] w, logic [3:0] nb, logic last);
      digest_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected digest beat %h", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.word) begin
        $error("digest_word exp %h got %h", e.word, w);
        errors++;
      end
      if (nb !== e.nbytes) begin
        $error("digest_word_bytes exp %0d got %0d", e.nbytes, nb);
        errors++;
      end
      if (last !== e.last) begin
        $error("digest_last exp %0d got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [63:0] in_message_word = '0;
  logic [3:0]  in_word_bytes = '0;
  logic        in_last_word = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] out_digest_word;
  logic [3:0]  out_digest_word_bytes;
  logic        out_digest_last;

  digest_scoreboard sb = new();
  bit          calm = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned sink_stall = 0;

  blake2b_keyed_hash_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_digest_word, out_digest_word_bytes, out_digest_last);

  always @(negedge clk) begin
    if (sink_stall > 0) sink_stall--;
    else if (!calm && $urandom_range(0, 4) == 0) sink_stall = $urandom_range(1, 7);
    out_ready <= rst_n && (sink_stall == 0);
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic last);
    in_valid = 1;
    in_message_word = w;
    in_word_bytes = nb;
    in_last_word = last;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w, nb, last);
    words_sent++;
    @(negedge clk);
    in_valid = 0;
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // key block: key_len bytes of key then zeros, always 16 beats
  task automatic send_key();
    int unsigned kl;
    logic [63:0] w;
    kl = (sb.key_len > 64) ? 64 : sb.key_len;
    for (int i = 0; i < 16; i++) begin
      w = rand_word();
      if (8 * i >= kl) w = '0;
      else if (8 * i + 8 > kl) w &= (64'd1 << (8 * (kl - 8 * i))) - 64'd1;
      send_word(w, 4'd8, 0);
    end
  endtask

  // n message beats after the optional key block, the last one carrying last_nb bytes
  task automatic send_msg(int unsigned n, logic [3:0] last_nb, bit keyed);
    if (keyed) send_key();
    for (int i = 0; i + 1 < n; i++)
      send_word(rand_word(), ($urandom_range(0, 5) == 0) ? 4'($urandom()) : 4'd8, 0);
    send_word(rand_word(), last_nb, 1);
  endtask

  initial begin
    int unsigned n;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: empty message, extremes of fields and registers, block edges
    send_msg(1, 4'd0, 0);
    send_word('1, 4'd8, 1);
    send_word('0, 4'd15, 1);
    send_msg(16, 4'd8, 0);
    send_msg(17, 4'd0, 0);
    send_msg(17, 4'd1, 0);
    send_word(rand_word(), 4'd3, 0);
    send_word(rand_word(), 4'd7, 1);
    drain();
    write_reg(REG_DIGEST_BYTES[0], 7'd1);
    write_reg(REG_KEY_BYTES[0], 7'd64);
    send_msg(2, 4'd5, 1);
    drain();
    write_reg(REG_DIGEST_BYTES[0], 7'd0);
    write_reg(REG_KEY_BYTES[0], 7'd127);
    send_msg(1, 4'd8, 1);
    drain();
    write_reg(REG_DIGEST_BYTES[0], 7'd127);
    write_reg(REG_KEY_BYTES[0], 7'd1);
    send_msg(3, 4'd2, 1);
    drain();

    while (words_sent < 118) begin
      if (words_sent > 100) calm = 1;
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_reg(REG_DIGEST_BYTES[0], ($urandom_range(0, 5) == 0) ?
                  7'($urandom()) : 7'($urandom_range(1, 64)));
        write_reg(REG_KEY_BYTES[0], ($urandom_range(0, 5) == 0) ?
                  7'($urandom()) : 7'($urandom_range(0, 64)));
      end
      case ($urandom_range(0, 9))
        0, 1: n = 16 * $urandom_range(1, 2) + $urandom_range(0, 1);
        2:    n = $urandom_range(18, 36);
        default: n = $urandom_range(1, 10);
      endcase
      send_msg(n, 4'($urandom()), (sb.key_len != 0) && ($urandom_range(0, 2) == 0));
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/b2b_pkg.sv
design/b2b_datapath.sv
design/b2b_ctrl.sv
design/blake2b_keyed_hash_unit.sv
dv/blake2b_keyed_hash_unit_tb.sv
